// ===== hdl/bitmap_slot_allocator_with_cache_defines.svh =====
// Assertion macros shared by the slot allocator RTL.
// Simulation builds get concurrent assertions; synthesis builds define SYNTH
// and the macros expand to nothing.
`ifndef BITMAP_SLOT_ALLOCATOR_WITH_CACHE_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_WITH_CACHE_DEFINES_SVH

`ifndef SYNTH

// Checked on every rising edge while reset is released.
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/bsa_pkg.sv =====
`default_nettype none

package bsa_pkg;

    // Default sizes, used as defaults of the top-level parameters.
    localparam int SLOT_COUNT_DEF  = 4096;
    localparam int CACHE_DEPTH_DEF = 64;

    // Fixed field widths.
    localparam int SLOT_W      = 13;
    localparam int META_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Bitmap words.
    localparam int WORD_W     = 64;
    localparam int WORD_LSB_W = 6;
    localparam int MAP_DEPTH_DEF = (SLOT_COUNT_DEF + WORD_W - 1) / WORD_W;

    localparam logic [SLOT_W-1:0] FREE_MAX       = '1;
    localparam logic [SLOT_W-1:0] SLOT_LIMIT_RST = 13'd4096;
    localparam logic [META_W-1:0] META_RST       = 4'd1;
    localparam logic              CACHE_EN_RST   = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLOT_LIMIT = 2'd0,
        CFG_META_SLOTS = 2'd1,
        CFG_CACHE_EN   = 2'd2
    } bsa_cfg_idx_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } bsa_action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT_FRESH  = 3'd0,
        ST_GRANT_CACHED = 3'd1,
        ST_FULL         = 3'd2,
        ST_FREED        = 3'd3,
        ST_CACHED       = 3'd4,
        ST_INVALID      = 3'd5
    } bsa_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_POP,
        S_FREE_RMW,
        S_RESULT
    } bsa_state_t;

    // Outcome of looking at one bitmap word during the allocation scan.
    typedef struct packed {
        logic                  past_end;
        logic                  hit;
        logic [WORD_LSB_W-1:0] bit_idx;
    } bsa_eval_t;

    // Index of the lowest set bit; the top index when no bit is set.
    function automatic logic [WORD_LSB_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_LSB_W-1:0] b;
        b = WORD_LSB_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                b = WORD_LSB_W'(i);
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bsa_ram.sv =====
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module bsa_ram #(
    parameter int DEPTH = bsa_pkg::MAP_DEPTH_DEF,
    parameter int WIDTH = bsa_pkg::WORD_W,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/bsa_word_eval.sv =====
`default_nettype none

// Looks at one bitmap word of the allocation scan: is it past the slot limit,
// and which clear bit below the limit is the lowest one.
module bsa_word_eval #(
    parameter int WIDX_W = 7
) (
    input  logic [WIDX_W-1:0]          word_idx,
    input  logic [bsa_pkg::WORD_W-1:0] word,
    input  logic [bsa_pkg::SLOT_W-1:0] lim,
    output bsa_pkg::bsa_eval_t         eval
);
    import bsa_pkg::*;

    localparam int CMPW = (WIDX_W + WORD_LSB_W > SLOT_W) ? WIDX_W + WORD_LSB_W : SLOT_W;

    logic [CMPW-1:0]   base;
    logic [CMPW-1:0]   lim_ext;
    logic              last_word;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] avail;

    assign base      = CMPW'({word_idx, {WORD_LSB_W{1'b0}}});
    assign lim_ext   = CMPW'(lim);
    assign last_word = CMPW'(lim[SLOT_W-1:WORD_LSB_W]) == CMPW'(word_idx);

    // The word holding the limit only offers the bits below it.
    assign mask  = last_word ? ((WORD_W'(1) << lim[WORD_LSB_W-1:0]) - WORD_W'(1)) : '1;
    assign avail = ~word & mask;

    always_comb
    begin
        eval.past_end = base >= lim_ext;
        eval.hit      = (base < lim_ext) && (avail != '0);
        eval.bit_idx  = lowest_set(avail);
    end

endmodule

`default_nettype wire

// ===== hdl/bitmap_slot_allocator_with_cache.sv =====
// Slot allocator for one segment: a last-in-first-out cache of freed slots in
// front of an occupancy bitmap held in a memory of 64-bit words.
// Items enter on the item channel (item_valid, item_stall; action, slot) and
// one result beat per item leaves on the result channel (result_valid,
// result_stall; granted_slot, status, free_slots). A beat moves at an edge
// where valid is high and stall is low. Configuration writes use cfg_valid and
// cfg_ready, which is always high. The user must see that they are made only
// while no item is in flight; the block itself does not enforce this.
// One item is worked on at a time. An invalid free, a free into the cache
// and a full report on a zero free count go from the dispatch state straight
// to the result state; a cached grant passes through the pop state and a free
// that reaches the bitmap through the read-modify-write state. A fresh grant
// scans the bitmap one word per cycle through the memory's single read port
// and reports full when no clear bit is left below the limit. A free that
// reaches the bitmap reads, modifies and writes back one word. The result sits
// in an output register, and the next item is taken while it still waits
// there; a stall on the result side then holds the following item before its
// own result is loaded. After reset the bitmap memory is cleared one word per
// cycle, and item_stall stays high until all of its words are cleared.
`default_nettype none
`include "bitmap_slot_allocator_with_cache_defines.svh"

module bitmap_slot_allocator_with_cache #(
    parameter int SLOT_COUNT  = bsa_pkg::SLOT_COUNT_DEF,
    parameter int CACHE_DEPTH = bsa_pkg::CACHE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Item channel.
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            action,
    input  logic [bsa_pkg::SLOT_W-1:0]      slot,
    // Result channel.
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [bsa_pkg::SLOT_W-1:0]      granted_slot,
    output logic [bsa_pkg::STATUS_W-1:0]    status,
    output logic [bsa_pkg::SLOT_W-1:0]      free_slots,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsa_pkg::*;

    localparam int MAP_WORDS = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int WW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CCW = $clog2(CACHE_DEPTH + 1);
    localparam int CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] SLOT_CAP =
        (SLOT_COUNT > int'(FREE_MAX)) ? FREE_MAX : SLOT_W'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LIM_RST =
        (SLOT_LIMIT_RST < SLOT_CAP) ? SLOT_LIMIT_RST : SLOT_CAP;

    // Control state.
    bsa_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] slot_limit_reg;
    logic [META_W-1:0] meta_reg;
    logic              cache_en_reg;
    logic [SLOT_W-1:0] free_count_reg, free_count_next;
    logic [CCW-1:0]    cache_count_reg, cache_count_next;
    logic [CCW-1:0]    cache_limit_reg, cache_limit_next;
    logic              overflow_reg, overflow_next;
    logic [WW:0]       rd_w_reg, rd_w_next;
    logic              dat_vld_reg, dat_vld_next;
    logic              result_valid_reg, result_valid_next;

    // Payload.
    bsa_action_t       item_action_reg;
    logic [SLOT_W-1:0] item_slot_reg;
    logic [WW:0]       dat_w_reg;
    logic [SLOT_W-1:0] res_granted_reg, res_granted_next;
    bsa_status_t       res_status_reg, res_status_next;
    logic [SLOT_W-1:0] granted_slot_reg;
    bsa_status_t       status_reg;
    logic [SLOT_W-1:0] free_slots_reg;

    // Memory ports.
    logic              map_we;
    logic [WW-1:0]     map_waddr;
    logic [WORD_W-1:0] map_wdata;
    logic [WW-1:0]     map_raddr;
    logic [WORD_W-1:0] map_rdata;
    logic              cache_we;
    logic [CAW-1:0]    cache_waddr;
    logic [SLOT_W-1:0] cache_rdata;

    // Decoded conditions.
    logic [SLOT_W-1:0] lim;
    logic [SLOT_W-1:0] cfg_lim;
    logic              cfg_we_limit;
    logic              cfg_we_meta;
    logic              cfg_we_cache;
    logic              item_take;
    logic              out_free;
    logic              clr_done;
    logic [SLOT_W-1:0] free_idx;
    logic [WW-1:0]     free_word;
    logic              slot_invalid;
    logic              cacheable;
    logic [CCW-1:0]    cnt_dec;
    logic [CCW:0]      limit_dbl;
    bsa_eval_t         eval;

    // Limit in effect: the register capped at the bitmap size.
    assign lim     = (slot_limit_reg < SLOT_CAP) ? slot_limit_reg : SLOT_CAP;
    assign cfg_lim = (cfg_data < SLOT_CAP) ? cfg_data : SLOT_CAP;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != S_IDLE);
    assign item_take  = (state_reg == S_IDLE) && item_valid;
    assign out_free   = !result_valid_reg || !result_stall;
    assign clr_done   = rd_w_reg == (WW + 1)'(MAP_WORDS - 1);

    // A free is rejected below the metadata area or at or past the limit.
    assign free_idx     = item_slot_reg - SLOT_W'(meta_reg);
    assign free_word    = WW'(free_idx[SLOT_W-1:WORD_LSB_W]);
    assign slot_invalid = (item_slot_reg < SLOT_W'(meta_reg)) || (free_idx >= lim);
    assign cacheable    = cache_en_reg && (cache_count_reg < cache_limit_reg) &&
                          (cache_count_reg < CCW'(CACHE_DEPTH));
    assign cnt_dec      = cache_count_reg - CCW'(1);
    assign limit_dbl    = {cache_limit_reg, 1'b0};

    always_comb
    begin
        cfg_we_limit = 1'b0;
        cfg_we_meta  = 1'b0;
        cfg_we_cache = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLOT_LIMIT: cfg_we_limit = 1'b1;
                CFG_META_SLOTS: cfg_we_meta  = 1'b1;
                CFG_CACHE_EN:   cfg_we_cache = 1'b1;
                default:        ;
            endcase
        end
    end

    bsa_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // The cache read port always points at the top entry; its data is registered,
    // and a pop uses it while the count has not moved.
    bsa_ram #(
        .DEPTH (CACHE_DEPTH),
        .WIDTH (SLOT_W)
    ) u_cache_ram (
        .clk   (clk),
        .we    (cache_we),
        .waddr (cache_waddr),
        .wdata (item_slot_reg),
        .raddr (cnt_dec[CAW-1:0]),
        .rdata (cache_rdata)
    );

    bsa_word_eval #(
        .WIDX_W (WW + 1)
    ) u_word_eval (
        .word_idx (dat_w_reg),
        .word     (map_rdata),
        .lim      (lim),
        .eval     (eval)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (item_action_reg == ACT_FREE)
                begin
                    state_next = (slot_invalid || cacheable) ? S_RESULT : S_FREE_RMW;
                end
                else if (free_count_reg == '0)
                begin
                    state_next = S_RESULT;
                end
                else if (cache_count_reg != '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (dat_vld_reg && (eval.past_end || eval.hit))
                begin
                    state_next = S_RESULT;
                end
            end
            S_POP:      state_next = S_RESULT;
            S_FREE_RMW: state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_CLEAR;
        endcase
    end

    // Datapath, memory controls and state updates per state.
    always_comb
    begin
        free_count_next   = free_count_reg;
        cache_count_next  = cache_count_reg;
        cache_limit_next  = cache_limit_reg;
        overflow_next     = overflow_reg;
        rd_w_next         = rd_w_reg;
        dat_vld_next      = dat_vld_reg;
        res_granted_next  = res_granted_reg;
        res_status_next   = res_status_reg;
        map_we            = 1'b0;
        map_waddr         = rd_w_reg[WW-1:0];
        map_wdata         = '0;
        map_raddr         = rd_w_reg[WW-1:0];
        cache_we          = 1'b0;
        cache_waddr       = cache_count_reg[CAW-1:0];

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                rd_w_next = clr_done ? '0 : rd_w_reg + (WW + 1)'(1);
            end
            S_IDLE:
            begin
            end
            S_DISPATCH:
            begin
                res_granted_next = '0;
                rd_w_next        = '0;
                dat_vld_next     = 1'b0;
                map_raddr        = free_word;
                if (item_action_reg == ACT_FREE)
                begin
                    if (slot_invalid)
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else if (cacheable)
                    begin
                        cache_we         = 1'b1;
                        cache_count_next = cache_count_reg + CCW'(1);
                        res_status_next  = ST_CACHED;
                    end
                end
                else
                begin
                    // Full is judged on the count alone, cached slots or not.
                    res_status_next = ST_FULL;
                end
            end
            S_SCAN:
            begin
                // One word read per cycle; the word read last cycle is judged.
                rd_w_next    = rd_w_reg + (WW + 1)'(1);
                dat_vld_next = 1'b1;
                if (dat_vld_reg && eval.hit)
                begin
                    map_we           = 1'b1;
                    map_waddr        = dat_w_reg[WW-1:0];
                    map_wdata        = map_rdata | (WORD_W'(1) << eval.bit_idx);
                    free_count_next  = free_count_reg - SLOT_W'(1);
                    res_granted_next = SLOT_W'({dat_w_reg, eval.bit_idx}) + SLOT_W'(meta_reg);
                    res_status_next  = ST_GRANT_FRESH;
                end
            end
            S_POP:
            begin
                cache_count_next = cnt_dec;
                res_granted_next = cache_rdata;
                res_status_next  = ST_GRANT_CACHED;
                // Emptying the cache after an overflow grows its limit.
                if ((cnt_dec == '0) && (cache_limit_reg != CCW'(CACHE_DEPTH)) && overflow_reg)
                begin
                    if (limit_dbl <= (CCW + 1)'(CACHE_DEPTH))
                    begin
                        cache_limit_next = limit_dbl[CCW-1:0];
                    end
                    else
                    begin
                        cache_limit_next = cache_limit_reg + CCW'(1);
                    end
                    overflow_next = 1'b0;
                end
            end
            S_FREE_RMW:
            begin
                map_we          = 1'b1;
                map_waddr       = free_word;
                map_wdata       = map_rdata & ~(WORD_W'(1) << free_idx[WORD_LSB_W-1:0]);
                overflow_next   = 1'b1;
                res_status_next = ST_FREED;
                if (free_count_reg < FREE_MAX)
                begin
                    free_count_next = free_count_reg + SLOT_W'(1);
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Writing the slot limit reloads the free count.
        if (cfg_we_limit)
        begin
            free_count_next = cfg_lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            slot_limit_reg   <= SLOT_LIMIT_RST;
            meta_reg         <= META_RST;
            cache_en_reg     <= CACHE_EN_RST;
            free_count_reg   <= LIM_RST;
            cache_count_reg  <= '0;
            cache_limit_reg  <= CCW'(1);
            overflow_reg     <= 1'b0;
            rd_w_reg         <= '0;
            dat_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_count_reg   <= free_count_next;
            cache_count_reg  <= cache_count_next;
            cache_limit_reg  <= cache_limit_next;
            overflow_reg     <= overflow_next;
            rd_w_reg         <= rd_w_next;
            dat_vld_reg      <= dat_vld_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we_limit)
            begin
                slot_limit_reg <= cfg_data;
            end
            if (cfg_we_meta)
            begin
                meta_reg <= cfg_data[META_W-1:0];
            end
            if (cfg_we_cache)
            begin
                cache_en_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_action_reg <= bsa_action_t'(action);
            item_slot_reg   <= slot;
        end
        dat_w_reg       <= rd_w_reg;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        if ((state_reg == S_RESULT) && out_free)
        begin
            granted_slot_reg <= res_granted_reg;
            status_reg       <= res_status_reg;
            free_slots_reg   <= free_count_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign granted_slot = granted_slot_reg;
    assign status       = status_reg;
    assign free_slots   = free_slots_reg;

    `BSA_ASSERT(a_cache_within_limit, clk, rst_n, cache_count_reg <= cache_limit_reg, "cache count exceeds cache limit")
    `BSA_ASSERT(a_limit_range, clk, rst_n, (cache_limit_reg != '0) && (cache_limit_reg <= CCW'(CACHE_DEPTH)), "cache limit out of range")
    `BSA_ASSERT_ALWAYS(a_clear_after_reset, clk, !rst_n |=> (state_reg == S_CLEAR), "no clear pass after reset")
    `BSA_ASSERT(a_scan_cache_empty, clk, rst_n, (state_reg == S_SCAN) |-> (cache_count_reg == '0), "bitmap scan with slots in the cache")
    `BSA_ASSERT(a_result_loaded, clk, rst_n, ((state_reg == S_RESULT) && out_free) |=> result_valid, "result not presented after load")

endmodule

`default_nettype wire
